### design/undirected_edge_table_macros.svh
// ----------------------------------------------------------------------------
// Undirected edge table assertion macros
// Shared assertion helpers for the edge table; they compile away under
// synthesis.
// ----------------------------------------------------------------------------
`ifndef UNDIRECTED_EDGE_TABLE_MACROS_SVH
`define UNDIRECTED_EDGE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define UTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define UTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define UTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/ute_pkg.sv
// ----------------------------------------------------------------------------
// Undirected edge table package
// Command codes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package ute_pkg;

  // Command carried on the input word's tuser.
  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_SEARCH     = 2'd1,
    CMD_DELETE     = 2'd2,
    CMD_SET_WEIGHT = 2'd3
  } cmd_t;

  // Result status.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2,
    S_DONE  = 2'd3
  } state_t;

endpackage

### design/ute_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module ute_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/undirected_edge_table.sv
// ----------------------------------------------------------------------------
// Undirected edge table
// Bounded table of weighted undirected edges, searched newest first, matched
// as unordered node pairs.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and answers each with exactly
// one result word. Every command first scans all stored entries, newest to
// oldest, through one RAM read port and one pair comparator, one entry per
// cycle. Insert then writes one slot, set weight rewrites matches during the
// scan itself, and delete closes the gap by moving each newer entry down one
// slot, one per cycle. The result word is then loaded into the output
// register. The table needs no clearing after reset: an empty count makes
// every slot invisible.
// ----------------------------------------------------------------------------
module undirected_edge_table
  import ute_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int NODE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // node_a[15:0], node_b[31:16], weight[63:32]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // found[0], status[2:1], match_weight[34:3]
);

`include "undirected_edge_table_macros.svh"

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = 2 * NODE_BITS + 32;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [NODE_BITS-1:0] node_a_r, node_a_nxt;
  logic [NODE_BITS-1:0] node_b_r, node_b_nxt;
  logic [31:0]          weight_r, weight_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     sh_src_r, sh_src_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic                 found_r, found_nxt;
  logic [ADDR_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [31:0]          hit_w_r, hit_w_nxt;
  status_t              status_r, status_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_found_r, out_found_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [31:0]          out_weight_r, out_weight_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [31:0]          in_a_ext, in_b_ext;
  logic [NODE_BITS-1:0] ent_p, ent_q;
  logic [31:0]          ent_w;
  logic                 ent_match;
  logic                 in_fire, scan_end, shift_end, out_free, table_full;

  // Entry storage: {first node, second node, weight}.
  ute_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and status terms shared by the sequencer.
  assign in_fire    = in_tvalid && in_tready;
  assign scan_end   = (rem_r == '0) && !rd_pend_r;
  assign shift_end  = (sh_src_r >= count_r) && !rd_pend_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign table_full = (count_r >= CNT_W'(CAPACITY));

  // Node identifiers are zero-extended, then cut to the stored width.
  assign in_a_ext = {16'd0, in_tdata[15:0]};
  assign in_b_ext = {16'd0, in_tdata[31:16]};

  // Shared pair comparator on the word just read.
  assign ent_p     = ram_rdata[ENTRY_W-1 -: NODE_BITS];
  assign ent_q     = ram_rdata[31 + NODE_BITS -: NODE_BITS];
  assign ent_w     = ram_rdata[31:0];
  assign ent_match = ((ent_p == node_a_r) && (ent_q == node_b_r)) ||
                     ((ent_p == node_b_r) && (ent_q == node_a_r));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = (cmd_r == CMD_DELETE && found_r) ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        if (shift_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, RAM control and result register.
  always_comb begin
    cmd_nxt        = cmd_r;
    node_a_nxt     = node_a_r;
    node_b_nxt     = node_b_r;
    weight_nxt     = weight_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    sh_src_nxt     = sh_src_r;
    rd_pend_nxt    = 1'b0;
    rd_addr_nxt    = rd_addr_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_w_nxt      = hit_w_r;
    status_nxt     = status_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_weight_nxt = out_weight_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = rd_addr_r;
    ram_wdata      = {node_a_r, node_b_r, weight_r};
    ram_raddr      = rd_addr_r;
    in_tready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          cmd_nxt    = cmd_t'(in_tuser);
          node_a_nxt = in_a_ext[NODE_BITS-1:0];
          node_b_nxt = in_b_ext[NODE_BITS-1:0];
          weight_nxt = in_tdata[63:32];
          rem_nxt    = count_r;
          found_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        // Issue reads newest first.
        if (rem_r != '0) begin
          ram_raddr   = ADDR_W'(rem_r - 1'b1);
          rd_addr_nxt = ADDR_W'(rem_r - 1'b1);
          rem_nxt     = rem_r - 1'b1;
          rd_pend_nxt = 1'b1;
        end
        // Compare the returned entry; the first hit is the newest match.
        if (rd_pend_r && ent_match) begin
          if (!found_r) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = rd_addr_r;
            hit_w_nxt   = ent_w;
          end
          if (cmd_r == CMD_SET_WEIGHT) begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_r;
            ram_wdata = {ent_p, ent_q, weight_r};
          end
        end
        // Scan finished: settle status and append on insert.
        if (scan_end) begin
          if (cmd_r == CMD_INSERT) begin
            status_nxt = table_full ? ST_FULL : ST_OK;
            if (!table_full) begin
              ram_we    = 1'b1;
              ram_waddr = count_r[ADDR_W-1:0];
              ram_wdata = {node_a_r, node_b_r, weight_r};
              count_nxt = count_r + 1'b1;
            end
          end else begin
            status_nxt = found_r ? ST_OK : ST_NO_MATCH;
          end
          sh_src_nxt = CNT_W'(hit_idx_r) + 1'b1;
        end
      end
      S_SHIFT: begin
        // Move each newer entry down one slot.
        if (sh_src_r < count_r) begin
          ram_raddr   = sh_src_r[ADDR_W-1:0];
          rd_addr_nxt = sh_src_r[ADDR_W-1:0];
          sh_src_nxt  = sh_src_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_r - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (shift_end) begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = found_r;
          out_status_nxt = status_r;
          out_weight_nxt = (cmd_r == CMD_SEARCH && found_r) ? hit_w_r : 32'd0;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    node_a_r     <= node_a_nxt;
    node_b_r     <= node_b_nxt;
    weight_r     <= weight_nxt;
    rem_r        <= rem_nxt;
    sh_src_r     <= sh_src_nxt;
    rd_addr_r    <= rd_addr_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_w_r      <= hit_w_nxt;
    status_r     <= status_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_weight_r <= out_weight_nxt;
  end

  // Result word.
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_weight_r, out_status_r, out_found_r};

  // Checks on the sequencer.
  `UTE_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY),
                   "entry count exceeds capacity")
  `UTE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !in_tready,
                   "new word accepted while a command is in progress")
  `UTE_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1,
                   count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
                   count_r == $past(count_r) - 1'b1,
                   "entry count moved by more than one")

endmodule
